[rtl/core/greedy_switch_frame_slot_assigner_core_macros.svh]
// Assertion macros for the frame slot assigner.
`ifndef GREEDY_SWITCH_FRAME_SLOT_ASSIGNER_CORE_MACROS_SVH
`define GREEDY_SWITCH_FRAME_SLOT_ASSIGNER_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GSFSA_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GSFSA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/gsfsa_pkg.sv]
package gsfsa_pkg;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;

    localparam logic [CFG_IDX_W-1:0] CFG_PORT_COUNT   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_LENGTH = 1'd1;

    localparam logic OP_ASSIGN      = 1'b0;
    localparam logic OP_FRAME_START = 1'b1;

    localparam logic [1:0] STAT_ASSIGNED      = 2'd0;
    localparam logic [1:0] STAT_NO_SLOT       = 2'd1;
    localparam logic [1:0] STAT_FRAME_CLEARED = 2'd2;
    localparam logic [1:0] STAT_OUT_OF_RANGE  = 2'd3;

    localparam logic [4:0] PORT_COUNT_RESET   = 5'd16;
    localparam logic [6:0] FRAME_LENGTH_RESET = 7'd64;

    typedef enum logic {
        ST_IDLE,
        ST_CALC
    } t_state;

endpackage

[rtl/core/greedy_switch_frame_slot_assigner_core.sv]
// Results: the port memories are read into registers when an input beat is taken, and
// the result is registered from them in the calc state, later only while the previous
// result still waits at the output. A new request is taken only in the idle state,
// after the previous one is committed, so the memory reads precede each read-modify-write.
// Reset: registers go to 16 ports and 64 slots, every map reads free, pointers and
// counts read zero through per-entry valid bits; there is no clearing pass.
`include "greedy_switch_frame_slot_assigner_core_macros.svh"

module greedy_switch_frame_slot_assigner_core #(
    parameter int PORTS     = 16,
    parameter int MAX_SLOTS = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_operation,
    input  logic [3:0]                    i_source_port,
    input  logic [3:0]                    i_dest_port,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [1:0]                    o_status,
    output logic [5:0]                    o_slot,
    output logic [6:0]                    o_probes,
    output logic [7:0]                    o_slots_needed,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [gsfsa_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [gsfsa_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import gsfsa_pkg::*;

    localparam int AW  = $clog2(PORTS);
    localparam int PW  = $clog2(MAX_SLOTS + 1);
    localparam int SIW = $clog2(MAX_SLOTS);
    localparam int WW  = 8 + PW + MAX_SLOTS;
    localparam int PLO = MAX_SLOTS;
    localparam int CLO = MAX_SLOTS + PW;

    // Port memories: one word per port holding {count, pointer, busy map}.
    logic [WW-1:0] r_src_mem [PORTS];
    logic [WW-1:0] r_dst_mem [PORTS];
    logic [WW-1:0] r_src_rd;
    logic [WW-1:0] r_dst_rd;
    logic [PORTS-1:0] r_src_vld;
    logic [PORTS-1:0] r_dst_vld;

    t_state r_state;
    t_state n_state;

    logic [4:0]    r_port_count;
    logic [6:0]    r_frame_length;
    logic [7:0]    r_base_cnt;
    logic [7:0]    r_needed_max;
    logic          r_req_op;
    logic          r_req_oor;
    logic [AW-1:0] r_src_addr;
    logic [AW-1:0] r_dst_addr;

    logic       r_out_valid;
    logic [1:0] r_status;
    logic [5:0] r_slot;
    logic [6:0] r_probes;

    logic          in_accept;
    logic          commit;
    logic          req_write;
    logic          oor;
    logic [AW-1:0] src_addr;
    logic [AW-1:0] dst_addr;

    logic [MAX_SLOTS-1:0] s_busy;
    logic [MAX_SLOTS-1:0] d_busy;
    logic [PW-1:0]        s_ptr;
    logic [PW-1:0]        d_ptr;
    logic [7:0]           s_cnt;
    logic [7:0]           d_cnt;
    logic [8:0]           start9;
    logic [8:0]           limit9;
    logic [MAX_SLOTS-1:0] free_map;
    logic                 found;
    logic [SIW-1:0]       found_idx;
    logic [8:0]           probes9;
    logic [6:0]           probes7;
    logic [MAX_SLOTS-1:0] slot_bit;
    logic [PW-1:0]        s_ptr_n;
    logic [PW-1:0]        d_ptr_n;
    logic [7:0]           s_cnt_n;
    logic [7:0]           d_cnt_n;
    logic [7:0]           max_n;
    logic [1:0]           status_n;
    logic [5:0]           slot_n;
    logic [6:0]           probes_n;
    logic [7:0]           needed_n;

    assign src_addr  = AW'(i_source_port);
    assign dst_addr  = AW'(i_dest_port);
    assign oor = ({1'b0, i_source_port} >= r_port_count) || ({1'b0, i_dest_port} >= r_port_count)
              || (32'(i_source_port) >= PORTS) || (32'(i_dest_port) >= PORTS);
    assign in_accept = i_in_valid && o_in_ready;
    assign req_write = commit && (r_req_op == OP_ASSIGN) && !r_req_oor;
    assign o_cfg_ready = 1'b1;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_accept) n_state = ST_CALC;
            end
            ST_CALC: begin
                if (!r_out_valid || i_out_ready) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Handshake and commit outputs of the sequencer.
    always_comb begin
        o_in_ready = 1'b0;
        commit     = 1'b0;
        case (r_state)
            ST_IDLE: o_in_ready = 1'b1;
            ST_CALC: commit = !r_out_valid || i_out_ready;
            default: begin
                o_in_ready = 1'b0;
                commit     = 1'b0;
            end
        endcase
    end

    // Unwritten entries read as the state left by reset or the last frame start.
    always_comb begin
        s_busy = r_src_vld[r_src_addr] ? r_src_rd[MAX_SLOTS-1:0] : '0;
        d_busy = r_dst_vld[r_dst_addr] ? r_dst_rd[MAX_SLOTS-1:0] : '0;
        s_ptr  = r_src_vld[r_src_addr] ? r_src_rd[CLO-1:PLO] : '0;
        d_ptr  = r_dst_vld[r_dst_addr] ? r_dst_rd[CLO-1:PLO] : '0;
        s_cnt  = r_src_vld[r_src_addr] ? r_src_rd[WW-1:CLO] : r_base_cnt;
        d_cnt  = r_dst_vld[r_dst_addr] ? r_dst_rd[WW-1:CLO] : r_base_cnt;
    end

    // Search window, common free map and lowest-slot encoder.
    always_comb begin
        start9 = (s_ptr > d_ptr) ? 9'(s_ptr) : 9'(d_ptr);
        limit9 = (32'(r_frame_length) < MAX_SLOTS) ? 9'(r_frame_length) : 9'(MAX_SLOTS);
        for (int k = 0; k < MAX_SLOTS; k++) begin
            free_map[k] = !s_busy[k] && !d_busy[k] && (9'(k) >= start9) && (9'(k) < limit9);
        end
        found     = |free_map;
        found_idx = '0;
        for (int k = MAX_SLOTS - 1; k >= 0; k--) begin
            if (free_map[k]) found_idx = SIW'(k);
        end
    end

    always_comb begin
        if (found) begin
            probes9 = 9'(found_idx) - start9 + 9'd1;
        end else if (start9 < limit9) begin
            probes9 = limit9 - start9;
        end else begin
            probes9 = '0;
        end
        probes7  = (probes9 > 9'd127) ? 7'd127 : probes9[6:0];
        slot_bit = found ? (MAX_SLOTS'(1) << found_idx) : '0;
        // A pointer moves only when the slot taken is the start slot it sat at.
        s_ptr_n  = (found && 9'(found_idx) == start9 && 9'(s_ptr) == start9) ? s_ptr + 1'b1 : s_ptr;
        d_ptr_n  = (found && 9'(found_idx) == start9 && 9'(d_ptr) == start9) ? d_ptr + 1'b1 : d_ptr;
        s_cnt_n  = (!found && s_cnt != 8'hFF) ? s_cnt + 8'd1 : s_cnt;
        d_cnt_n  = (!found && d_cnt != 8'hFF) ? d_cnt + 8'd1 : d_cnt;
        max_n    = r_needed_max;
        if (s_cnt_n > max_n) max_n = s_cnt_n;
        if (d_cnt_n > max_n) max_n = d_cnt_n;
    end

    always_comb begin
        status_n = STAT_OUT_OF_RANGE;
        slot_n   = '0;
        probes_n = '0;
        needed_n = r_needed_max;
        if (r_req_op == OP_FRAME_START) begin
            status_n = STAT_FRAME_CLEARED;
            needed_n = {1'b0, r_frame_length};
        end else if (!r_req_oor) begin
            status_n = found ? STAT_ASSIGNED : STAT_NO_SLOT;
            slot_n   = found ? 6'(found_idx) : 6'd0;
            probes_n = probes7;
            needed_n = max_n;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_src_rd <= r_src_mem[src_addr];
            r_dst_rd <= r_dst_mem[dst_addr];
        end
        if (req_write) begin
            r_src_mem[r_src_addr] <= {s_cnt_n, s_ptr_n, s_busy | slot_bit};
            r_dst_mem[r_dst_addr] <= {d_cnt_n, d_ptr_n, d_busy | slot_bit};
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_req_op   <= i_operation;
            r_req_oor  <= oor;
            r_src_addr <= src_addr;
            r_dst_addr <= dst_addr;
        end
        if (commit) begin
            r_status <= status_n;
            r_slot   <= slot_n;
            r_probes <= probes_n;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_port_count   <= PORT_COUNT_RESET;
            r_frame_length <= FRAME_LENGTH_RESET;
            r_base_cnt     <= '0;
            r_needed_max   <= '0;
            r_src_vld      <= '0;
            r_dst_vld      <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_PORT_COUNT:   r_port_count   <= i_cfg_data[4:0];
                    CFG_FRAME_LENGTH: r_frame_length <= i_cfg_data[6:0];
                    default: ;
                endcase
            end
            if (commit) begin
                r_out_valid  <= 1'b1;
                r_needed_max <= needed_n;
                if (r_req_op == OP_FRAME_START) begin
                    r_src_vld  <= '0;
                    r_dst_vld  <= '0;
                    r_base_cnt <= {1'b0, r_frame_length};
                end else if (req_write) begin
                    r_src_vld[r_src_addr] <= 1'b1;
                    r_dst_vld[r_dst_addr] <= 1'b1;
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_status;
    assign o_slot         = r_slot;
    assign o_probes       = r_probes;
    assign o_slots_needed = r_needed_max;

    `GSFSA_ASSERT_NEXT(a_accept_to_calc, i_clk, i_rst_n, in_accept, r_state == ST_CALC, "accepted beat did not start a search")
    `GSFSA_ASSERT_SAME(a_assigned_probed, i_clk, i_rst_n, r_out_valid && o_status == STAT_ASSIGNED, o_probes != 7'd0, "assigned slot with no probe")
    `GSFSA_ASSERT_SAME(a_cleared_quiet, i_clk, i_rst_n, r_out_valid && o_status == STAT_FRAME_CLEARED, o_probes == 7'd0 && o_slot == 6'd0, "frame start reported a search")
    `GSFSA_ASSERT_SAME(a_slot_in_window, i_clk, i_rst_n, req_write && found, 9'(found_idx) >= start9 && 9'(found_idx) < limit9, "slot outside search window")

endmodule

[tb/greedy_switch_frame_slot_assigner_core_tb.sv]
module greedy_switch_frame_slot_assigner_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import gsfsa_pkg::*;

    localparam int NPORTS    = 16;
    localparam int NSLOTS    = 64;
    localparam int RAND_ITEMS = 1650;

    typedef struct {
        logic [1:0] status;
        logic [5:0] slot;
        logic [6:0] probes;
        logic [7:0] slots_needed;
    } t_grant;

    typedef enum logic [1:0] {
        ROW_ITEM,
        ROW_SET_PORTS,
        ROW_SET_FRAME
    } t_row_kind;

    typedef struct {
        t_row_kind  kind;
        logic       op;
        logic [3:0] src;
        logic [3:0] dst;
        logic [6:0] cfg_val;
        bit         typed;
        t_grant     grant;
    } t_dir_row;

    localparam t_grant NO_GRANT = '{STAT_ASSIGNED, 0, 0, 0};
    localparam int DIR_ROWS = 30;

    // Rows with typed set carry a result that can be read straight off the behaviour;
    // the others are left to the predictor.
    t_dir_row dir_rows [DIR_ROWS] = '{
        '{ROW_ITEM, OP_ASSIGN, 0, 0, 0, 1, '{STAT_ASSIGNED, 0, 1, 0}},
        '{ROW_ITEM, OP_ASSIGN, 0, 0, 0, 1, '{STAT_ASSIGNED, 1, 1, 0}},
        '{ROW_ITEM, OP_ASSIGN, 15, 15, 0, 1, '{STAT_ASSIGNED, 0, 1, 0}},
        '{ROW_ITEM, OP_ASSIGN, 0, 15, 0, 0, NO_GRANT},
        '{ROW_ITEM, OP_ASSIGN, 15, 0, 0, 0, NO_GRANT},
        '{ROW_ITEM, OP_FRAME_START, 7, 9, 0, 1, '{STAT_FRAME_CLEARED, 0, 0, 64}},
        '{ROW_SET_FRAME, OP_ASSIGN, 0, 0, 2, 0, NO_GRANT},
        '{ROW_ITEM, OP_FRAME_START, 0, 0, 0, 1, '{STAT_FRAME_CLEARED, 0, 0, 2}},
        '{ROW_ITEM, OP_ASSIGN, 3, 4, 0, 1, '{STAT_ASSIGNED, 0, 1, 2}},
        '{ROW_ITEM, OP_ASSIGN, 3, 4, 0, 1, '{STAT_ASSIGNED, 1, 1, 2}},
        '{ROW_ITEM, OP_ASSIGN, 3, 4, 0, 1, '{STAT_NO_SLOT, 0, 0, 3}},
        '{ROW_ITEM, OP_ASSIGN, 3, 5, 0, 1, '{STAT_NO_SLOT, 0, 0, 4}},
        '{ROW_ITEM, OP_ASSIGN, 6, 4, 0, 0, NO_GRANT},
        '{ROW_SET_FRAME, OP_ASSIGN, 0, 0, 127, 0, NO_GRANT},
        '{ROW_ITEM, OP_ASSIGN, 6, 5, 0, 0, NO_GRANT},
        '{ROW_SET_PORTS, OP_ASSIGN, 0, 0, 5, 0, NO_GRANT},
        '{ROW_ITEM, OP_ASSIGN, 5, 0, 0, 1, '{STAT_OUT_OF_RANGE, 0, 0, 4}},
        '{ROW_ITEM, OP_ASSIGN, 0, 15, 0, 0, NO_GRANT},
        '{ROW_SET_FRAME, OP_ASSIGN, 0, 0, 1, 0, NO_GRANT},
        '{ROW_ITEM, OP_ASSIGN, 3, 4, 0, 0, NO_GRANT},
        '{ROW_SET_FRAME, OP_ASSIGN, 0, 0, 0, 0, NO_GRANT},
        '{ROW_ITEM, OP_FRAME_START, 0, 0, 0, 1, '{STAT_FRAME_CLEARED, 0, 0, 0}},
        '{ROW_ITEM, OP_ASSIGN, 1, 1, 0, 1, '{STAT_NO_SLOT, 0, 0, 1}},
        '{ROW_SET_PORTS, OP_ASSIGN, 0, 0, 0, 0, NO_GRANT},
        '{ROW_ITEM, OP_ASSIGN, 0, 0, 0, 1, '{STAT_OUT_OF_RANGE, 0, 0, 1}},
        '{ROW_SET_PORTS, OP_ASSIGN, 0, 0, 7'h70, 0, NO_GRANT},
        '{ROW_SET_FRAME, OP_ASSIGN, 0, 0, 64, 0, NO_GRANT},
        '{ROW_ITEM, OP_FRAME_START, 10, 5, 0, 1, '{STAT_FRAME_CLEARED, 0, 0, 64}},
        '{ROW_ITEM, OP_ASSIGN, 15, 15, 0, 1, '{STAT_ASSIGNED, 0, 1, 64}},
        '{ROW_ITEM, OP_ASSIGN, 8, 7, 0, 0, NO_GRANT}
    };

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_ready;
    logic                  i_operation;
    logic [3:0]            i_source_port;
    logic [3:0]            i_dest_port;
    logic                  o_out_valid;
    logic                  i_out_ready;
    logic [1:0]            o_status;
    logic [5:0]            o_slot;
    logic [6:0]            o_probes;
    logic [7:0]            o_slots_needed;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    // Predictor state: entries below NPORTS are input ports, the rest output ports.
    logic [NSLOTS-1:0] port_busy [2*NPORTS];
    int unsigned       free_ptr [2*NPORTS];
    int unsigned       miss_count [2*NPORTS];
    int unsigned       miss_max;
    int unsigned       cfg_ports;
    int unsigned       cfg_frame;

    t_grant      pending_grants [$];
    int unsigned mismatch_count = 0;
    int unsigned in_idle_pct = 0;
    int unsigned out_stall_pct = 0;

    greedy_switch_frame_slot_assigner_core #(
        .PORTS     (NPORTS),
        .MAX_SLOTS (NSLOTS)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_operation    (i_operation),
        .i_source_port  (i_source_port),
        .i_dest_port    (i_dest_port),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_status       (o_status),
        .o_slot         (o_slot),
        .o_probes       (o_probes),
        .o_slots_needed (o_slots_needed),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

    function automatic void bump_miss(int unsigned entry);
        if (miss_count[entry] < 255)
            miss_count[entry]++;
        if (miss_count[entry] > miss_max)
            miss_max = miss_count[entry];
    endfunction

    function automatic t_grant predict_grant(logic op, logic [3:0] src, logic [3:0] dst);
        t_grant      g;
        int unsigned se, de, lim, ps, pd, first, idx, nprobe;
        bit          hit;
        g = NO_GRANT;
        nprobe = 0;
        hit = 1'b0;
        if (op == OP_FRAME_START) begin
            for (int k = 0; k < 2*NPORTS; k++) begin
                port_busy[k] = '0;
                free_ptr[k] = 0;
                miss_count[k] = cfg_frame;
            end
            miss_max = cfg_frame;
            g.status = STAT_FRAME_CLEARED;
        end else if (src >= cfg_ports || dst >= cfg_ports) begin
            g.status = STAT_OUT_OF_RANGE;
        end else begin
            se = src;
            de = NPORTS + dst;
            lim = (cfg_frame < NSLOTS) ? cfg_frame : NSLOTS;
            ps = free_ptr[se];
            pd = free_ptr[de];
            first = (ps > pd) ? ps : pd;
            for (idx = first; idx < lim && !hit; idx++) begin
                nprobe++;
                if (!port_busy[se][idx] && !port_busy[de][idx]) begin
                    hit = 1'b1;
                    port_busy[se][idx] = 1'b1;
                    port_busy[de][idx] = 1'b1;
                    // Only a pointer that sat on the start slot moves on.
                    if (idx == first && ps == first)
                        free_ptr[se]++;
                    if (idx == first && pd == first)
                        free_ptr[de]++;
                    g.slot = idx[5:0];
                end
            end
            if (hit) begin
                g.status = STAT_ASSIGNED;
            end else begin
                bump_miss(se);
                bump_miss(de);
                g.status = STAT_NO_SLOT;
            end
        end
        g.probes = (nprobe > 127) ? 7'd127 : nprobe[6:0];
        g.slots_needed = miss_max[7:0];
        return g;
    endfunction

    // Entered at a falling edge; leaves at the falling edge after the beat is taken,
    // with valid still high so that the next call may keep it there.
    task automatic send_request(input logic op, input logic [3:0] src, input logic [3:0] dst,
                                input bit typed, input t_grant fixed);
        t_grant g;
        while ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_operation   <= op;
        i_source_port <= src;
        i_dest_port   <= dst;
        do @(posedge i_clk); while (!o_in_ready);
        g = predict_grant(op, src, dst);
        pending_grants.push_back(typed ? fixed : g);
        @(negedge i_clk);
    endtask

    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        while (pending_grants.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        wait_for_results();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == CFG_PORT_COUNT)
            cfg_ports = data & 7'h1F;
        else
            cfg_frame = data;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= out_stall_pct);
    end

    always @(posedge i_clk) begin
        t_grant want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_grants.size() == 0) begin
                $display("%0t: result beat with nothing outstanding, status %0d slot %0d",
                         $time, o_status, o_slot);
                mismatch_count++;
            end else begin
                want = pending_grants.pop_front();
                if (o_status !== want.status) begin
                    $display("%0t: status expected %0d, actual %0d",
                             $time, want.status, o_status);
                    mismatch_count++;
                end
                if (o_slot !== want.slot) begin
                    $display("%0t: slot expected %0d, actual %0d", $time, want.slot, o_slot);
                    mismatch_count++;
                end
                if (o_probes !== want.probes) begin
                    $display("%0t: probes expected %0d, actual %0d",
                             $time, want.probes, o_probes);
                    mismatch_count++;
                end
                if (o_slots_needed !== want.slots_needed) begin
                    $display("%0t: slots_needed expected %0d, actual %0d",
                             $time, want.slots_needed, o_slots_needed);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        int unsigned items_left, batch, top, roll, pick, hi, ports_val, frame_val;
        int unsigned phase;
        logic        op;
        logic [3:0]  src, dst;
        bit          fresh;

        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_operation   = OP_ASSIGN;
        i_source_port = '0;
        i_dest_port   = '0;
        i_out_ready   = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = CFG_PORT_COUNT;
        i_cfg_data    = '0;

        cfg_ports = PORT_COUNT_RESET;
        cfg_frame = FRAME_LENGTH_RESET;
        miss_max  = 0;
        for (int k = 0; k < 2*NPORTS; k++) begin
            port_busy[k] = '0;
            free_ptr[k] = 0;
            miss_count[k] = 0;
        end

        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (dir_rows[r]) begin
            if (dir_rows[r].kind == ROW_ITEM)
                send_request(dir_rows[r].op, dir_rows[r].src, dir_rows[r].dst,
                             dir_rows[r].typed, dir_rows[r].grant);
            else if (dir_rows[r].kind == ROW_SET_PORTS)
                write_register(CFG_PORT_COUNT, dir_rows[r].cfg_val);
            else
                write_register(CFG_FRAME_LENGTH, dir_rows[r].cfg_val);
        end

        items_left = RAND_ITEMS;
        for (phase = 0; items_left > 0; phase++) begin
            case (phase % 4)
                0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
                1: begin in_idle_pct = 82; out_stall_pct = 0;  end
                2: begin in_idle_pct = 0;  out_stall_pct = 82; end
                default: begin in_idle_pct = 8; out_stall_pct = 8; end
            endcase

            if (phase == 1) begin
                // One port and one slot, with a single frame start at the head of the batch: nearly
                // every request misses, so the counts climb into saturation.
                write_register(CFG_PORT_COUNT, 7'd1);
                write_register(CFG_FRAME_LENGTH, 7'd1);
                batch = 300;
                fresh = 1'b1;
            end else begin
                if ($urandom_range(9) < 7) begin
                    pick = $urandom_range(19);
                    ports_val = (pick == 0) ? $urandom_range(31) :
                                (pick < 4)  ? 1 :
                                (pick < 8)  ? 16 : $urandom_range(16, 1);
                    hi = $urandom_range(3);
                    write_register(CFG_PORT_COUNT, 7'(hi * 32 + ports_val));
                end
                if ($urandom_range(9) < 7) begin
                    pick = $urandom_range(31);
                    frame_val = (pick == 0) ? 0 :
                                (pick < 3)  ? $urandom_range(127, 65) :
                                (pick < 7)  ? 1 :
                                (pick < 11) ? 64 : $urandom_range(64, 1);
                    write_register(CFG_FRAME_LENGTH, 7'(frame_val));
                end
                batch = $urandom_range(100, 20);
                fresh = ($urandom_range(4) != 0);
            end
            if (batch > items_left)
                batch = items_left;

            if (fresh) begin
                send_request(OP_FRAME_START, 4'($urandom_range(15)), 4'($urandom_range(15)),
                             1'b0, NO_GRANT);
                batch--;
                items_left--;
            end

            top = (cfg_ports > NPORTS) ? NPORTS : cfg_ports;
            repeat (batch) begin
                roll = $urandom_range(99);
                if (roll < 3 && phase != 1) begin
                    op = OP_FRAME_START;
                    src = 4'($urandom_range(15));
                    dst = 4'($urandom_range(15));
                end else if (roll < 8 || top == 0) begin
                    op = OP_ASSIGN;
                    src = 4'($urandom_range(15));
                    dst = 4'($urandom_range(15));
                end else begin
                    op = OP_ASSIGN;
                    src = 4'($urandom_range(top - 1));
                    dst = 4'($urandom_range(top - 1));
                end
                send_request(op, src, dst, 1'b0, NO_GRANT);
            end
            items_left -= batch;
        end

        wait_for_results();

        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

[files.f]
+incdir+rtl/core
rtl/core/gsfsa_pkg.sv
rtl/core/greedy_switch_frame_slot_assigner_core.sv
tb/greedy_switch_frame_slot_assigner_core_tb.sv
